// ===== src/pce_pkg.sv =====
package pce_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ALPHA      = 26;
  localparam int LETTER_W   = 5;
  localparam int OPCODE_W   = 2;
  localparam int IDX_W      = $clog2(GRID_SIDE + 1);
  localparam int CELL_W     = $clog2(GRID_CELLS);

  localparam logic [LETTER_W-1:0] LET_I    = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] LET_J    = LETTER_W'(9);
  localparam logic [LETTER_W-1:0] LET_X    = LETTER_W'(23);
  localparam logic [LETTER_W-1:0] LET_LAST = LETTER_W'(ALPHA - 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_KEY_LETTER  = 2'd0,
    OP_KEY_END     = 2'd1,
    OP_TEXT_LETTER = 2'd2,
    OP_TEXT_END    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_A,
    ST_POS_B,
    ST_CELL_A,
    ST_CELL_B,
    ST_OUT_A,
    ST_OUT_B
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } pos_t;

  function automatic logic [CELL_W-1:0] cell_addr(input pos_t p);
    cell_addr = CELL_W'(CELL_W'(p.row) * CELL_W'(GRID_SIDE) + CELL_W'(p.col));
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
    next_idx = (x == IDX_W'(GRID_SIDE - 1)) ? '0 : IDX_W'(x + 1'b1);
  endfunction

endpackage

// ===== src/pce_if.sv =====
interface pce_in_if import pce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, output opcode, output letter, input ready);
  modport sink   (input valid, input opcode, input letter, output ready);
endinterface

interface pce_out_if import pce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cipher_letter;
  logic                last_of_pair;

  modport source (output valid, output cipher_letter, output last_of_pair, input ready);
  modport sink   (input valid, input cipher_letter, input last_of_pair, output ready);
endinterface

// ===== src/playfair_cipher_encryptor_top.sv =====
// Playfair encryptor, 5x5 grid with j folded into i.
// Input channel in_ch carries an opcode and a letter (a=0..z=25): key letters,
// then key end, then text letters and text end. Output channel out_ch carries
// cipher letters, two per encrypted pair, last_of_pair high on the second.
// Key letters, non-pairing text letters and ignored items are taken in ST_IDLE.
// Key end walks the alphabet through the shared placement logic in ST_FILL.
// A pair costs two position-memory reads and two grid-memory reads in series;
// the first cipher letter becomes valid once ST_POS_A, ST_POS_B, ST_CELL_A
// and ST_CELL_B have run after the transfer that completes the pair, the
// second in the cycle after the first is taken. in_ch.ready is low from the
// completing transfer until the second result is taken.
// A receiver stall holds the result in the output register and holds the
// block; nothing is lost.
// Reset (rst_n low, synchronous) clears the key, the pending letter and the
// output; the grid memory is rewritten as each new key is loaded and is not cleared.
module playfair_cipher_encryptor_top import pce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pce_in_if.sink     in_ch,
  pce_out_if.source  out_ch
);

  state_t              state_r, state_nxt;
  logic [ALPHA-1:0]    used_r, used_nxt;
  pos_t                fill_r, fill_nxt;
  logic                key_ready_r, key_ready_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [LETTER_W-1:0] pend_letter_r, pend_letter_nxt;
  logic [LETTER_W-1:0] k_r, k_nxt;
  logic [LETTER_W-1:0] a_r, b_r;
  pos_t                pa_r;
  logic [CELL_W-1:0]   eb_r;
  pos_t                pos_q;
  logic [LETTER_W-1:0] grid_q;
  logic                out_valid_r;
  logic [LETTER_W-1:0] out_letter_r;
  logic                out_last_r;

  logic [LETTER_W-1:0] grid_mem [GRID_CELLS];
  pos_t                pos_mem  [ALPHA];

  logic                in_fire, out_fire;
  op_t                 in_op;
  logic [LETTER_W-1:0] in_char;
  logic                in_ok;
  logic                place_req, place_do;
  logic [LETTER_W-1:0] place_char;
  logic                enc_start;
  logic [LETTER_W-1:0] enc_a, enc_b;
  logic                pos_rd_en, grid_rd_en;
  logic [LETTER_W-1:0] pos_rd_addr;
  logic [CELL_W-1:0]   grid_rd_addr;
  pos_t                ea_pos, eb_pos;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_op    = op_t'(in_ch.opcode);
  assign in_char  = (in_ch.letter == LET_J) ? LET_I : in_ch.letter;
  assign in_ok    = in_ch.letter < LETTER_W'(ALPHA);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cipher_letter = out_letter_r;
  assign out_ch.last_of_pair  = out_last_r;

  always_comb begin
    if (state_r == ST_FILL) begin
      place_req  = (k_r != LET_J);
      place_char = k_r;
    end else begin
      place_req  = in_fire && (in_op == OP_KEY_LETTER) && !key_ready_r && in_ok;
      place_char = in_char;
    end
    place_do = place_req && !used_r[place_char] && (fill_r.row < IDX_W'(GRID_SIDE));
  end

  always_comb begin
    ea_pos = pa_r;
    eb_pos = pos_q;
    if (pa_r.row == pos_q.row) begin
      ea_pos.col = next_idx(pa_r.col);
      eb_pos.col = next_idx(pos_q.col);
    end else if (pa_r.col == pos_q.col) begin
      ea_pos.row = next_idx(pa_r.row);
      eb_pos.row = next_idx(pos_q.row);
    end else begin
      ea_pos.col = pos_q.col;
      eb_pos.col = pa_r.col;
    end
  end

  always_comb begin
    used_nxt        = used_r;
    fill_nxt        = fill_r;
    key_ready_nxt   = key_ready_r;
    pend_valid_nxt  = pend_valid_r;
    pend_letter_nxt = pend_letter_r;
    k_nxt           = k_r;
    enc_start       = 1'b0;
    enc_a           = pend_letter_r;
    enc_b           = LET_X;
    if (place_do) begin
      used_nxt[place_char] = 1'b1;
      fill_nxt.col = next_idx(fill_r.col);
      if (fill_r.col == IDX_W'(GRID_SIDE - 1)) begin
        fill_nxt.row = IDX_W'(fill_r.row + 1'b1);
      end
    end
    if (state_r == ST_FILL) begin
      k_nxt = LETTER_W'(k_r + 1'b1);
      if (k_r == LET_LAST) begin
        key_ready_nxt = 1'b1;
      end
    end else if (in_fire) begin
      case (in_op)
        OP_KEY_END: begin
          k_nxt = '0;
        end
        OP_TEXT_LETTER: begin
          if (key_ready_r && in_ok) begin
            if (!pend_valid_r) begin
              pend_valid_nxt  = 1'b1;
              pend_letter_nxt = in_char;
            end else if (in_char == pend_letter_r) begin
              enc_start = 1'b1;
            end else begin
              enc_start      = 1'b1;
              enc_b          = in_char;
              pend_valid_nxt = 1'b0;
            end
          end
        end
        OP_TEXT_END: begin
          if (key_ready_r && pend_valid_r) begin
            enc_start      = 1'b1;
            pend_valid_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_op == OP_KEY_END && !key_ready_r) begin
          state_nxt = ST_FILL;
        end else if (enc_start) begin
          state_nxt = ST_POS_A;
        end
      end
      ST_FILL: begin
        if (k_r == LET_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POS_A:  state_nxt = ST_POS_B;
      ST_POS_B:  state_nxt = ST_CELL_A;
      ST_CELL_A: state_nxt = ST_CELL_B;
      ST_CELL_B: state_nxt = ST_OUT_A;
      ST_OUT_A: begin
        if (out_ch.ready) begin
          state_nxt = ST_OUT_B;
        end
      end
      ST_OUT_B: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    pos_rd_en    = 1'b0;
    grid_rd_en   = 1'b0;
    pos_rd_addr  = b_r;
    grid_rd_addr = eb_r;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_POS_A: begin
        pos_rd_en   = 1'b1;
        pos_rd_addr = a_r;
      end
      ST_POS_B: pos_rd_en = 1'b1;
      ST_CELL_A: begin
        grid_rd_en   = 1'b1;
        grid_rd_addr = cell_addr(ea_pos);
      end
      ST_CELL_B: grid_rd_en = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (place_do) begin
      grid_mem[cell_addr(fill_r)] <= place_char;
      pos_mem[place_char]         <= fill_r;
    end
    if (pos_rd_en) begin
      pos_q <= pos_mem[pos_rd_addr];
    end
    if (grid_rd_en) begin
      grid_q <= grid_mem[grid_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (enc_start) begin
      a_r <= enc_a;
      b_r <= enc_b;
    end
    if (state_r == ST_POS_B) begin
      pa_r <= pos_q;
    end
    if (state_r == ST_CELL_A) begin
      eb_r <= cell_addr(eb_pos);
    end
    if (state_r == ST_CELL_B) begin
      out_letter_r <= grid_q;
      out_last_r   <= 1'b0;
    end else if (state_r == ST_OUT_A && out_fire) begin
      out_letter_r <= grid_q;
      out_last_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      used_r        <= '0;
      fill_r        <= '0;
      key_ready_r   <= 1'b0;
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      used_r        <= used_nxt;
      fill_r        <= fill_nxt;
      key_ready_r   <= key_ready_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
      k_r           <= k_nxt;
      if (state_r == ST_CELL_B) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_OUT_B && out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pce_checker.sv =====
module pce_checker import pce_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LETTER_W-1:0] out_letter,
  input logic                out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_letter) && $stable(out_last))
    else $error("stalled result changed");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_letter < LETTER_W'(ALPHA))
    else $error("cipher letter out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second letter of pair missing");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind playfair_cipher_encryptor_top pce_checker u_pce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_letter (out_ch.cipher_letter),
  .out_last   (out_ch.last_of_pair)
);
